// ===== rtl/core/vlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vlt_pkg;

    localparam int ADDR_W  = 64;
    localparam int STAMP_W = 63;
    localparam int ENTRY_W = 64;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] MODE_QUERY    = 2'd0;
    localparam logic [1:0] MODE_ACQUIRE  = 2'd1;
    localparam logic [1:0] MODE_REL_NEW  = 2'd2;
    localparam logic [1:0] MODE_REL_KEEP = 2'd3;

    localparam logic [CFG_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ELEMENT_SIZE = 2'd1;
    localparam logic [CFG_W-1:0] CFG_ENTRY_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] new_timestamp;
    } t_req;

    typedef struct packed {
        logic               in_range;
        logic               locked;
        logic [STAMP_W-1:0] timestamp;
        logic               acquired;
    } t_rsp;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/vlt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vlt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/vlt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vlt_div
    import vlt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(ADDR_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [ADDR_W-1:0] r_quo, n_quo;
    logic [SIZE_W-1:0] r_dvs, n_dvs;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;

    always_comb begin
        trial  = {r_rem, r_quo[ADDR_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[SIZE_W-1:0];
                n_quo = {r_quo[ADDR_W-2:0], 1'b1};
            end else begin
                n_rem = trial[SIZE_W-1:0];
                n_quo = {r_quo[ADDR_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ADDR_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/versioned_lock_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Versioned lock table: one 64-bit entry per protected element, lock bit on
// top of a 63-bit timestamp.
// Request channel: a transaction is taken on a clock edge with start high and
// busy low; i_req carries mode, byte address and new timestamp.
// Result channel: o_done is high for one cycle with o_rsp valid; the receiver
// cannot stall, so every result must be taken in that cycle.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_index
// (0 base address, 1 element size, 2 entry count) at once; write only while
// idle.
// Processing: an in-range request runs 64 steps of the bit-serial divider that
// maps the address offset to an entry index; the index is checked against the
// bound as the divider finishes, then ST_READ and ST_EXEC read the entry and,
// by mode, write it back. An index past the entries in use or ENTRIES gets
// in_range 0. Requests with zero element size, zero entry count or an address
// below the base return in_range 0 on the next cycle and leave busy low.
// Flow: one request in flight; after a divided request busy stays high until
// the state machine is back in idle, so the next request waits until then.
// Reset: after i_rst_n is released the table is swept to zero, one entry per
// cycle, through all ENTRIES entries; busy is high during the sweep.
module versioned_lock_table
    import vlt_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_req                  i_req,
    output logic                       o_done,
    output t_rsp                       o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_clr, n_clr;
    logic                r_done, n_done;
    t_rsp                r_rsp, n_rsp;
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_size;
    logic [COUNT_W-1:0]  r_count;
    logic [1:0]          r_mode, n_mode;
    logic [STAMP_W-1:0]  r_stamp, n_stamp;
    logic [IDX_W-1:0]    r_index, n_index;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [ADDR_W-1:0]   offset;
    logic                early_out;
    logic                accept;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    assign accept    = start && !busy;
    assign offset    = i_req.address - r_base;
    assign early_out = (r_size == '0) || (r_count == '0) || (i_req.address < r_base);

    assign div_req.start    = accept && !early_out;
    assign div_req.dividend = offset;
    assign div_req.divisor  = r_size;

    vlt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    vlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_index),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_mode    = r_mode;
        n_stamp   = r_stamp;
        n_index   = r_index;
        ram_we    = 1'b0;
        ram_waddr = r_index;
        ram_wdata = ram_rdata;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == IDX_W'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_mode  = i_req.mode;
                    n_stamp = i_req.new_timestamp;
                    if (early_out) begin
                        n_done = 1'b1;
                        n_rsp  = '0;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if ((div_rsp.quotient < {{(ADDR_W-COUNT_W){1'b0}}, r_count})
                            && (div_rsp.quotient < ADDR_W'(ENTRIES))) begin
                        n_index = div_rsp.quotient[IDX_W-1:0];
                        n_state = ST_READ;
                    end else begin
                        n_done  = 1'b1;
                        n_rsp   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_done           = 1'b1;
                n_rsp.in_range   = 1'b1;
                n_rsp.locked     = ram_rdata[ENTRY_W-1];
                n_rsp.timestamp  = ram_rdata[STAMP_W-1:0];
                n_rsp.acquired   = 1'b0;
                unique case (r_mode)
                    MODE_QUERY: begin
                        ram_we = 1'b0;
                    end
                    MODE_ACQUIRE: begin
                        if (!ram_rdata[ENTRY_W-1]) begin
                            ram_we         = 1'b1;
                            ram_wdata      = {1'b1, ram_rdata[STAMP_W-1:0]};
                            n_rsp.acquired = 1'b1;
                        end
                    end
                    MODE_REL_NEW: begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, r_stamp};
                    end
                    MODE_REL_KEEP: begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, ram_rdata[STAMP_W-1:0]};
                    end
                endcase
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_base  <= '0;
            r_size  <= SIZE_W'(8);
            r_count <= COUNT_W'(1024);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_ADDRESS: r_base  <= i_cfg_data;
                    CFG_ELEMENT_SIZE: r_size  <= i_cfg_data[SIZE_W-1:0];
                    CFG_ENTRY_COUNT:  r_count <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp   <= n_rsp;
        r_mode  <= n_mode;
        r_stamp <= n_stamp;
        r_index <= n_index;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire
